FILE: hw/rtl/fixed_partition_fit_allocator_macros.svh
// Assertion macros used by the allocator checker.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define FPFA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpfa assertion failed");

// Next-cycle implication, masked while reset is high.
`define FPFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpfa assertion failed");

// Next-cycle implication that also holds across reset.
`define FPFA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fpfa assertion failed");

`endif

FILE: hw/rtl/fpfa_pkg.sv
// Shared types and codes of the fixed-partition fit allocator.
package fpfa_pkg;

  // Command codes
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Fit policies; the unused code behaves as first fit
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // Register map (word index taken from paddr[2])
  localparam int         APB_ADDR_W      = 3;
  localparam logic       REG_FIT_MODE    = 1'b0;
  localparam logic       REG_BLOCK_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  block_index;
    logic [15:0] size_value;
  } req_t;

  typedef struct packed {
    logic        granted;
    logic [3:0]  partition_number;
    logic [15:0] leftover;
  } rsp_t;

  // Settings and broadcast controls seen by every cell
  typedef struct packed {
    logic [1:0] fit_mode;
    logic [4:0] block_count;
    logic       clear;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/fpfa_cell.sv
// One partition cell: holds a size and occupancy mark, updates the passing scan token.
module fpfa_cell #(
  parameter int CELL_INDEX = 0,
  parameter int SIZE_WIDTH = 16,
  parameter int IDX_WIDTH  = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fpfa_pkg::cell_ctl_t   ctl,
  input  logic                  load_en,
  input  logic [SIZE_WIDTH-1:0] load_size,
  input  logic                  set_occ,
  input  logic                  tin_valid,
  input  logic                  tin_found,
  input  logic [IDX_WIDTH-1:0]  tin_pick,
  input  logic [SIZE_WIDTH-1:0] tin_req,
  input  logic [SIZE_WIDTH-1:0] tin_best,
  output logic                  tout_valid,
  output logic                  tout_found,
  output logic [IDX_WIDTH-1:0]  tout_pick,
  output logic [SIZE_WIDTH-1:0] tout_req,
  output logic [SIZE_WIDTH-1:0] tout_best
);
  import fpfa_pkg::*;

  logic [SIZE_WIDTH-1:0] size_q;
  logic                  occ;
  logic                  in_range;
  logic                  fits;
  logic                  take;

  // Partition size, written by load
  always_ff @(posedge clk) begin
    if (load_en) begin
      size_q <= load_size;
    end
  end

  // Occupancy mark
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctl.clear) begin
      occ <= 1'b0;
    end else if (set_occ) begin
      occ <= 1'b1;
    end
  end

  // Candidate test and policy compare
  always_comb begin
    in_range = {27'b0, ctl.block_count} > 32'(CELL_INDEX);
    fits     = tin_valid && in_range && !occ && (size_q >= tin_req);
    take     = 1'b0;
    if (!tin_found) begin
      take = fits;
    end else begin
      case (ctl.fit_mode)
        FIT_BEST:  take = fits && (size_q < tin_best);
        FIT_WORST: take = fits && (size_q > tin_best);
        default:   take = 1'b0;
      endcase
    end
  end

  // Token hand-off to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tout_valid <= 1'b0;
    end else begin
      tout_valid <= tin_valid;
    end
  end

  always_ff @(posedge clk) begin
    tout_req   <= tin_req;
    tout_found <= tin_found | take;
    tout_pick  <= take ? IDX_WIDTH'(CELL_INDEX) : tin_pick;
    tout_best  <= take ? size_q : tin_best;
  end

endmodule

FILE: hw/rtl/fixed_partition_fit_allocator.sv
// Top level of the fixed-partition fit allocator: cell chain, result stage, APB registers.
//
//   channel  | direction | handshake              | payload
//   req      | in        | req_valid / req_ready  | fpfa_pkg::req_t (cmd, index, size)
//   rsp      | out       | rsp_valid / rsp_ready  | fpfa_pkg::rsp_t (grant, number, leftover)
//   apb      | in        | psel, penable, pready  | paddr, pwdata, prdata
//
// Load and clear requests do not close the request channel. An allocate request walks
// the row of NUM_PARTITIONS cells, one cell per cycle; the next request can enter once
// its result reaches the output register.
// The chosen partition is marked at the same edge that registers the result.
// Reset frees all partitions and zeroes both registers at once; sizes stay unset.
// A stalled result waits in a hold register; no new request enters until it moves out.
module fixed_partition_fit_allocator #(
  parameter int NUM_PARTITIONS = 16,
  parameter int SIZE_WIDTH     = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  fpfa_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output fpfa_pkg::rsp_t                      rsp,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fpfa_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import fpfa_pkg::*;

  localparam int IW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;

  logic [1:0]            fit_mode;
  logic [4:0]            block_count;
  logic                  busy;
  logic                  accept;
  cell_ctl_t             ctl;

  logic                  tok_valid [0:NUM_PARTITIONS];
  logic                  tok_found [0:NUM_PARTITIONS];
  logic [IW-1:0]         tok_pick  [0:NUM_PARTITIONS];
  logic [SIZE_WIDTH-1:0] tok_req   [0:NUM_PARTITIONS];
  logic [SIZE_WIDTH-1:0] tok_best  [0:NUM_PARTITIONS];

  logic                  hold_valid;
  rsp_t                  hold;
  rsp_t                  tail_rsp;
  logic                  rsp_free;

  // APB register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode    <= FIT_FIRST;
      block_count <= 5'd0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_FIT_MODE:    fit_mode    <= pwdata[1:0];
        REG_BLOCK_COUNT: block_count <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FIT_MODE:    prdata = {30'b0, fit_mode};
      REG_BLOCK_COUNT: prdata = {27'b0, block_count};
      default:         prdata = 32'b0;
    endcase
  end

  // Request intake
  assign req_ready = !busy;
  assign accept    = req_valid && req_ready;

  assign ctl.fit_mode    = fit_mode;
  assign ctl.block_count = block_count;
  assign ctl.clear       = accept && (req.cmd == CMD_CLEAR);

  assign tok_valid[0] = accept && (req.cmd == CMD_ALLOC);
  assign tok_found[0] = 1'b0;
  assign tok_pick[0]  = '0;
  assign tok_req[0]   = SIZE_WIDTH'(req.size_value);
  assign tok_best[0]  = '0;

  // Row of partition cells
  for (genvar i = 0; i < NUM_PARTITIONS; i++) begin : g_cell
    logic load_en;
    logic set_occ;

    assign load_en = accept && (req.cmd == CMD_LOAD) &&
                     ({28'b0, req.block_index} == 32'(i));
    assign set_occ = tok_valid[NUM_PARTITIONS] && tok_found[NUM_PARTITIONS] &&
                     (tok_pick[NUM_PARTITIONS] == IW'(i));

    fpfa_cell #(
      .CELL_INDEX (i),
      .SIZE_WIDTH (SIZE_WIDTH),
      .IDX_WIDTH  (IW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .load_en    (load_en),
      .load_size  (SIZE_WIDTH'(req.size_value)),
      .set_occ    (set_occ),
      .tin_valid  (tok_valid[i]),
      .tin_found  (tok_found[i]),
      .tin_pick   (tok_pick[i]),
      .tin_req    (tok_req[i]),
      .tin_best   (tok_best[i]),
      .tout_valid (tok_valid[i+1]),
      .tout_found (tok_found[i+1]),
      .tout_pick  (tok_pick[i+1]),
      .tout_req   (tok_req[i+1]),
      .tout_best  (tok_best[i+1])
    );
  end

  // Result formed from the token leaving the last cell
  always_comb begin
    tail_rsp = '0;
    if (tok_found[NUM_PARTITIONS]) begin
      tail_rsp.granted          = 1'b1;
      tail_rsp.partition_number = 4'(tok_pick[NUM_PARTITIONS]);
      tail_rsp.leftover         = 16'(tok_best[NUM_PARTITIONS] - tok_req[NUM_PARTITIONS]);
    end
  end

  assign rsp_free = !rsp_valid || rsp_ready;

  // Output register with a hold slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      hold_valid <= 1'b0;
      busy       <= 1'b0;
    end else begin
      if (hold_valid && rsp_free) begin
        rsp_valid  <= 1'b1;
        hold_valid <= 1'b0;
        busy       <= 1'b0;
      end else if (tok_valid[NUM_PARTITIONS]) begin
        if (rsp_free) begin
          rsp_valid <= 1'b1;
          busy      <= 1'b0;
        end else begin
          hold_valid <= 1'b1;
        end
      end else begin
        if (rsp_free) begin
          rsp_valid <= 1'b0;
        end
        if (tok_valid[0]) begin
          busy <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_valid && rsp_free) begin
      rsp <= hold;
    end else if (tok_valid[NUM_PARTITIONS] && rsp_free) begin
      rsp <= tail_rsp;
    end
    if (tok_valid[NUM_PARTITIONS] && !rsp_free) begin
      hold <= tail_rsp;
    end
  end

endmodule

FILE: hw/rtl/fpfa_checker.sv
// Port-level checker for the fit allocator, bound to the top level.
`include "fixed_partition_fit_allocator_macros.svh"

module fpfa_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input fpfa_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input fpfa_pkg::rsp_t rsp
);
  import fpfa_pkg::*;

  // A waiting result is not withdrawn
  `FPFA_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)

  // Reset leaves no result pending
  `FPFA_ASSERT_NEXT_ALWAYS(a_rst_empty, clk, rst, !rsp_valid)

  // A refused request reports zero number and leftover
  `FPFA_ASSERT_IMPLY(a_refuse_zero, clk, rst, rsp_valid && !rsp.granted,
                     rsp.partition_number == 4'd0 && rsp.leftover == 16'd0)

  // An accepted allocate closes the request channel while it scans
  `FPFA_ASSERT_NEXT(a_alloc_busy, clk, rst,
                    req_valid && req_ready && req.cmd == CMD_ALLOC, !req_ready)

endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

FILE: bench/testbench.sv
// Testbench for the fixed-partition fit allocator: directed table, random requests, scoreboard.
`timescale 1ns / 1ps

module testbench;
  import fpfa_pkg::*;

  localparam int NUM_PARTITIONS = 16;
  localparam int SETTLE_CYCLES  = NUM_PARTITIONS + 4;
  localparam int LONG_HOLD      = 400;
  localparam int IDLE_LIMIT     = 3000;
  localparam int NUM_PHASES     = 12;
  localparam int PER_PHASE      = 90;
  localparam int MAX_PRINTED    = 50;

  // Codes the package leaves unnamed
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] FIT_UNUSED = 2'd3;

  localparam logic [APB_ADDR_W-1:0] ADDR_FIT_MODE    = {REG_FIT_MODE, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_BLOCK_COUNT = {REG_BLOCK_COUNT, 2'b00};

  // One step of the directed part: a register write or a request
  typedef struct {
    bit                    is_write;
    logic [APB_ADDR_W-1:0] addr;
    logic [31:0]           data;
    req_t                  item;
    bit                    typed;
    rsp_t                  want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  req_t                  req = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  rsp_t                  rsp;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // Predictor state
  logic [15:0] part_size [NUM_PARTITIONS];
  logic [15:0] occupied = '0;
  logic [1:0]  cfg_mode = FIT_FIRST;
  logic [4:0]  cfg_count = '0;

  rsp_t expected_grants[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  bit   quiet = 1'b0;
  bit   gap_on = 1'b1;
  bit   long_hold = 1'b0;

  plan_row_t plan[$];

  fixed_partition_fit_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got_val,
                                 input logic [31:0] want_val);
    if (mismatches < MAX_PRINTED)
      $display("MISMATCH %s: got %0h, expected %0h", what, got_val, want_val);
    mismatches++;
  endtask

  // Allocation search: first, best or worst fit over free partitions in range
  function automatic rsp_t pick_partition(input logic [15:0] request);
    rsp_t       r;
    int         limit;
    bit         found;
    bit         done;
    logic [3:0] pick;
    r = '0;
    found = 1'b0;
    done = 1'b0;
    pick = '0;
    limit = (cfg_count > NUM_PARTITIONS) ? NUM_PARTITIONS : cfg_count;
    for (int j = 0; j < limit; j++) begin
      if (!done && !occupied[j] && part_size[j] >= request) begin
        if (!found) begin
          found = 1'b1;
          pick = j[3:0];
          // unused mode behaves as first fit
          if (cfg_mode != FIT_BEST && cfg_mode != FIT_WORST) done = 1'b1;
        end else if (cfg_mode == FIT_BEST && part_size[j] < part_size[pick]) begin
          pick = j[3:0];
        end else if (cfg_mode == FIT_WORST && part_size[j] > part_size[pick]) begin
          pick = j[3:0];
        end
      end
    end
    if (found) begin
      occupied[pick] = 1'b1;
      r.granted = 1'b1;
      r.partition_number = pick;
      r.leftover = part_size[pick] - request;
    end
    return r;
  endfunction

  function automatic plan_row_t req_row(input logic [1:0] cmd, input logic [3:0] idx,
                                        input logic [15:0] size);
    plan_row_t row;
    row = '{default: '0};
    row.item = {cmd, idx, size};
    return row;
  endfunction

  function automatic plan_row_t fixed_row(input logic [1:0] cmd, input logic [3:0] idx,
                                          input logic [15:0] size, input logic granted,
                                          input logic [3:0] number, input logic [15:0] rest);
    plan_row_t row;
    row = req_row(cmd, idx, size);
    row.typed = 1'b1;
    row.want = {granted, number, rest};
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [APB_ADDR_W-1:0] addr,
                                        input logic [31:0] data);
    plan_row_t row;
    row = '{default: '0};
    row.is_write = 1'b1;
    row.addr = addr;
    row.data = data;
    return row;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   roll;
    roll = $urandom_range(0, 99);
    r.block_index = 4'($urandom_range(0, NUM_PARTITIONS - 1));
    r.size_value = 16'($urandom);
    if (roll < 55) begin
      r.cmd = CMD_ALLOC;
      case ($urandom_range(0, 2))
        0: r.size_value = 16'($urandom_range(0, 255));
        1: r.size_value = 16'($urandom_range(0, 9000));
        default: ;
      endcase
    end else if (roll < 80) begin
      r.cmd = CMD_LOAD;
      // a coarse pool of sizes makes ties common
      if ($urandom_range(0, 1) == 1) r.size_value = 16'($urandom_range(0, 8) * 1000);
    end else if (roll < 93) begin
      r.cmd = CMD_CLEAR;
    end else begin
      r.cmd = CMD_UNUSED;
    end
    return r;
  endfunction

  // Offer one request, wait for acceptance, then update the predictor
  task automatic send_item(input req_t item, input bit typed, input rsp_t want);
    rsp_t model_rsp;
    if (!quiet && gap_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    case (item.cmd)
      CMD_LOAD: part_size[item.block_index] = item.size_value;
      CMD_ALLOC: begin
        model_rsp = pick_partition(item.size_value);
        expected_grants.push_back(typed ? want : model_rsp);
      end
      CMD_CLEAR: occupied = '0;
      default: ;
    endcase
  endtask

  // Stop offering and wait until the block has gone idle
  task automatic settle();
    req_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[2] == REG_FIT_MODE) cfg_mode = value[1:0];
    else cfg_count = value[4:0];
  endtask

  // Response side pacing: random stalls, one long hold-off, none at the end
  initial begin : rsp_pacing
    bit held;
    held = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (long_hold && !held) begin
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Scoreboard: each result against the oldest expectation
  always @(posedge clk) begin : grant_check
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_grants.size() == 0) begin
        report_mismatch("result with none expected", 32'(rsp), 32'd0);
      end else begin
        want = expected_grants.pop_front();
        if (rsp.granted !== want.granted)
          report_mismatch("granted", 32'(rsp.granted), 32'(want.granted));
        if (rsp.partition_number !== want.partition_number)
          report_mismatch("partition_number", 32'(rsp.partition_number),
                          32'(want.partition_number));
        if (rsp.leftover !== want.leftover)
          report_mismatch("leftover", 32'(rsp.leftover), 32'(want.leftover));
      end
    end
  end

  // Watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [1:0] mode_cycle [4];
    logic [4:0] count;
    req_t       item;
    int         counted;
    mode_cycle = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_UNUSED};

    // Directed part: four partitions 100, 50, 200, 50
    plan.push_back(fixed_row(CMD_ALLOC, 4'd0, 16'd0, 1'b0, 4'd0, 16'd0));
    plan.push_back(reg_row(ADDR_BLOCK_COUNT, 32'd4));
    plan.push_back(req_row(CMD_LOAD, 4'd0, 16'd100));
    plan.push_back(req_row(CMD_LOAD, 4'd1, 16'd50));
    plan.push_back(req_row(CMD_LOAD, 4'd2, 16'd200));
    plan.push_back(req_row(CMD_LOAD, 4'd3, 16'd50));
    plan.push_back(req_row(CMD_ALLOC, 4'd0, 16'd60));
    plan.push_back(req_row(CMD_ALLOC, 4'd0, 16'd0));
    plan.push_back(fixed_row(CMD_ALLOC, 4'd0, 16'd201, 1'b0, 4'd0, 16'd0));
    plan.push_back(req_row(CMD_CLEAR, 4'd0, 16'd0));
    plan.push_back(reg_row(ADDR_FIT_MODE, 32'(FIT_BEST)));
    // equal sizes: lowest index first
    plan.push_back(req_row(CMD_ALLOC, 4'd0, 16'd50));
    plan.push_back(req_row(CMD_ALLOC, 4'd0, 16'd50));
    plan.push_back(req_row(CMD_ALLOC, 4'd0, 16'd60));
    plan.push_back(req_row(CMD_CLEAR, 4'd0, 16'd0));
    plan.push_back(reg_row(ADDR_FIT_MODE, 32'(FIT_WORST)));
    plan.push_back(req_row(CMD_ALLOC, 4'd0, 16'd10));
    plan.push_back(req_row(CMD_ALLOC, 4'd0, 16'd10));
    // reload of an occupied partition keeps its mark
    plan.push_back(req_row(CMD_LOAD, 4'd0, 16'hFFFF));
    plan.push_back(req_row(CMD_ALLOC, 4'd0, 16'd1));
    plan.push_back(req_row(CMD_CLEAR, 4'd0, 16'd0));
    plan.push_back(fixed_row(CMD_ALLOC, 4'd0, 16'hFFFF, 1'b1, 4'd0, 16'd0));
    plan.push_back(reg_row(ADDR_FIT_MODE, 32'(FIT_UNUSED)));
    plan.push_back(req_row(CMD_ALLOC, 4'd0, 16'd0));
    plan.push_back(req_row(CMD_UNUSED, 4'd9, 16'h1234));
    plan.push_back(req_row(CMD_LOAD, 4'd15, 16'd0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        settle();
        write_reg(plan[i].addr, plan[i].data);
      end else begin
        send_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    // Load every partition before any search can reach it
    for (int i = 0; i < NUM_PARTITIONS; i++) begin
      item = {CMD_LOAD, 4'(i), 16'($urandom)};
      send_item(item, 1'b0, '0);
    end

    // Random phases, each under its own setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      case (phase % 6)
        0: count = 5'd16;
        1: count = 5'd31;
        2: count = 5'd0;
        3: count = 5'd1;
        default: count = 5'($urandom_range(2, 31));
      endcase
      write_reg(ADDR_FIT_MODE, 32'(mode_cycle[phase % 4]));
      write_reg(ADDR_BLOCK_COUNT, 32'(count));
      gap_on = (phase % 3 != 2);
      if (phase == 3) long_hold <= 1'b1;
      if (phase == NUM_PHASES - 2) quiet <= 1'b1;
      counted = 0;
      while (counted < PER_PHASE) begin
        item = random_request();
        send_item(item, 1'b0, '0);
        if (item.cmd != CMD_UNUSED) counted++;
        // sender pause until all results are back
        if (phase == 5 && counted == PER_PHASE / 2) settle();
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
